// File: sv/tqpr_pkg.sv
// ----------------------------------------------------------------------------
// tqpr_pkg: shared types and codes for the two-queue page replacement block
// Holds the list codes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package tqpr_pkg;

   localparam logic [1:0] FOUND_NEW   = 2'd0;
   localparam logic [1:0] FOUND_IN    = 2'd1;
   localparam logic [1:0] FOUND_GHOST = 2'd2;
   localparam logic [1:0] FOUND_MAIN  = 2'd3;

   localparam logic [1:0] REG_INPUT_LIMIT = 2'd0;
   localparam logic [1:0] REG_GHOST_LIMIT = 2'd1;
   localparam logic [1:0] REG_MAIN_LIMIT  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic dummy;
   } status_type;

endpackage

// File: sv/tqpr_ctrl.sv
// ----------------------------------------------------------------------------
// tqpr_ctrl: request sequencer
// Accepts a word, runs the list update, then offers the result word.
// ----------------------------------------------------------------------------
module tqpr_ctrl
   import tqpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_OUTPUT);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.update = (state_ff == ST_UPDATE);
   end

`ifndef ASSERT_OFF
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_UPDATE) else $error("load did not advance");
   a_upd_out: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid) else $error("update gave no result");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("result while open");
`endif

endmodule

// File: sv/tqpr_datapath.sv
// ----------------------------------------------------------------------------
// tqpr_datapath: three ranked lists, tag compare and rank update
// Slots below the count are live; rank zero is the front of a list.
// ----------------------------------------------------------------------------
module tqpr_datapath
   import tqpr_pkg::*;
#(
   parameter int IN_DEPTH    = 16,
   parameter int GHOST_DEPTH = 32,
   parameter int MAIN_DEPTH  = 16,
   parameter int PAGE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [31:0] req_page,
   input  logic [4:0]  input_limit,
   input  logic [5:0]  ghost_limit,
   input  logic [4:0]  main_limit,
   output logic        rsp_hit,
   output logic [1:0]  rsp_found_in,
   output logic        rsp_dropped_valid,
   output logic [31:0] rsp_dropped_page,
   output logic [31:0] rsp_hits_so_far
);

   localparam int IW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
   localparam int GW = (GHOST_DEPTH > 1) ? $clog2(GHOST_DEPTH) : 1;
   localparam int MW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
   localparam int IC = $clog2(IN_DEPTH + 1);
   localparam int GC = $clog2(GHOST_DEPTH + 1);
   localparam int MC = $clog2(MAIN_DEPTH + 1);

   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] in_pg_ff [IN_DEPTH];
   logic [IW-1:0]        in_rk_ff [IN_DEPTH];
   logic [IC-1:0]        in_cnt_ff;
   logic [PAGE_BITS-1:0] gh_pg_ff [GHOST_DEPTH];
   logic [GW-1:0]        gh_rk_ff [GHOST_DEPTH];
   logic [GC-1:0]        gh_cnt_ff;
   logic [PAGE_BITS-1:0] mn_pg_ff [MAIN_DEPTH];
   logic [MW-1:0]        mn_rk_ff [MAIN_DEPTH];
   logic [MC-1:0]        mn_cnt_ff;
   logic [31:0]          hits_ff;
   logic                 hit_ff, dv_ff;
   logic [1:0]           where_ff;
   logic [31:0]          dp_ff;

   logic [PAGE_BITS-1:0] in_pg_in [IN_DEPTH];
   logic [IW-1:0]        in_rk_in [IN_DEPTH];
   logic [IC-1:0]        in_cnt_in;
   logic [PAGE_BITS-1:0] gh_pg_in [GHOST_DEPTH];
   logic [GW-1:0]        gh_rk_in [GHOST_DEPTH];
   logic [GC-1:0]        gh_cnt_in;
   logic [PAGE_BITS-1:0] mn_pg_in [MAIN_DEPTH];
   logic [MW-1:0]        mn_rk_in [MAIN_DEPTH];
   logic [MC-1:0]        mn_cnt_in;
   logic                 hit_in, dv_in;
   logic [1:0]           where_in;
   logic [31:0]          dp_in;

   logic [IC-1:0] lim_in;
   logic [GC-1:0] lim_gh;
   logic [MC-1:0] lim_mn;
   logic          in_f, gh_f, mn_f;
   logic [IW-1:0] in_s, in_t;
   logic [GW-1:0] gh_s, gh_t;
   logic [MW-1:0] mn_s, mn_t;

   always_comb begin
      lim_in = (input_limit == 5'd0) ? IC'(1) :
               (32'(input_limit) > IN_DEPTH) ? IC'(IN_DEPTH) : IC'(input_limit);
      lim_gh = (ghost_limit == 6'd0) ? GC'(1) :
               (32'(ghost_limit) > GHOST_DEPTH) ? GC'(GHOST_DEPTH) : GC'(ghost_limit);
      lim_mn = (32'(main_limit) > MAIN_DEPTH) ? MC'(MAIN_DEPTH) : MC'(main_limit);
   end

   // find first match and tail slot in each list
   always_comb begin
      in_f = 1'b0; in_s = '0; in_t = '0;
      for (int i = IN_DEPTH - 1; i >= 0; i--) begin
         if (IC'(i) < in_cnt_ff) begin
            if (in_pg_ff[i] == page_ff) begin
               in_f = 1'b1; in_s = IW'(i);
            end
            if (IC'(in_rk_ff[i]) == in_cnt_ff - IC'(1)) in_t = IW'(i);
         end
      end
      gh_f = 1'b0; gh_s = '0; gh_t = '0;
      for (int i = GHOST_DEPTH - 1; i >= 0; i--) begin
         if (GC'(i) < gh_cnt_ff) begin
            if (gh_pg_ff[i] == page_ff) begin
               gh_f = 1'b1; gh_s = GW'(i);
            end
            if (GC'(gh_rk_ff[i]) == gh_cnt_ff - GC'(1)) gh_t = GW'(i);
         end
      end
      mn_f = 1'b0; mn_s = '0; mn_t = '0;
      for (int i = MAIN_DEPTH - 1; i >= 0; i--) begin
         if (MC'(i) < mn_cnt_ff) begin
            if (mn_pg_ff[i] == page_ff) begin
               mn_f = 1'b1; mn_s = MW'(i);
            end
            if (MC'(mn_rk_ff[i]) == mn_cnt_ff - MC'(1)) mn_t = MW'(i);
         end
      end
   end

   always_comb begin
      logic [IW-1:0]        r_i;
      logic [GW-1:0]        r_g;
      logic [MW-1:0]        r_m;
      logic [PAGE_BITS-1:0] q;
      logic [IC-1:0]        ilast;
      logic [GC-1:0]        glast;
      logic [MC-1:0]        mlast;
      in_pg_in = in_pg_ff; in_rk_in = in_rk_ff; in_cnt_in = in_cnt_ff;
      gh_pg_in = gh_pg_ff; gh_rk_in = gh_rk_ff; gh_cnt_in = gh_cnt_ff;
      mn_pg_in = mn_pg_ff; mn_rk_in = mn_rk_ff; mn_cnt_in = mn_cnt_ff;
      hit_in = 1'b1; where_in = FOUND_NEW; dv_in = 1'b0; dp_in = '0;
      q = '0; r_i = '0; r_g = '0; r_m = '0;
      ilast = '0; glast = '0; mlast = '0;
      priority if (in_f) begin
         where_in = FOUND_IN;
         r_i = in_rk_ff[in_s];
         for (int i = 0; i < IN_DEPTH; i++)
            if (IC'(i) < in_cnt_ff && in_rk_ff[i] < r_i) in_rk_in[i] = in_rk_ff[i] + 1'b1;
         in_rk_in[in_s] = '0;
      end else if (gh_f) begin
         where_in = FOUND_GHOST;
         if (lim_mn != '0) begin
            if (mn_cnt_ff >= lim_mn && mn_cnt_ff != '0) begin
               dv_in = 1'b1;
               dp_in = 32'(mn_pg_ff[mn_t]);
               r_m = mn_rk_ff[mn_t];
               for (int i = 0; i < MAIN_DEPTH; i++)
                  if (MC'(i) < mn_cnt_ff && mn_rk_ff[i] > r_m)
                     mn_rk_in[i] = mn_rk_ff[i] - 1'b1;
               mlast = mn_cnt_ff - MC'(1);
               mn_pg_in[mn_t] = mn_pg_ff[mlast[MW-1:0]];
               mn_rk_in[mn_t] = mn_rk_in[mlast[MW-1:0]];
               mn_cnt_in = mlast;
            end
            r_g = gh_rk_ff[gh_s];
            for (int i = 0; i < GHOST_DEPTH; i++)
               if (GC'(i) < gh_cnt_ff && gh_rk_ff[i] > r_g) gh_rk_in[i] = gh_rk_ff[i] - 1'b1;
            glast = gh_cnt_ff - GC'(1);
            gh_pg_in[gh_s] = gh_pg_ff[glast[GW-1:0]];
            gh_rk_in[gh_s] = gh_rk_in[glast[GW-1:0]];
            gh_cnt_in = glast;
            if (32'(mn_cnt_in) < MAIN_DEPTH) begin
               for (int i = 0; i < MAIN_DEPTH; i++)
                  if (MC'(i) < mn_cnt_in) mn_rk_in[i] = mn_rk_in[i] + 1'b1;
               mn_pg_in[mn_cnt_in[MW-1:0]] = page_ff;
               mn_rk_in[mn_cnt_in[MW-1:0]] = '0;
               mn_cnt_in = mn_cnt_in + MC'(1);
            end
         end
      end else if (mn_f) begin
         where_in = FOUND_MAIN;
         r_m = mn_rk_ff[mn_s];
         for (int i = 0; i < MAIN_DEPTH; i++)
            if (MC'(i) < mn_cnt_ff && mn_rk_ff[i] < r_m) mn_rk_in[i] = mn_rk_ff[i] + 1'b1;
         mn_rk_in[mn_s] = '0;
      end else begin
         hit_in = 1'b0;
         if (in_cnt_ff >= lim_in && in_cnt_ff != '0) begin
            q = in_pg_ff[in_t];
            r_i = in_rk_ff[in_t];
            for (int i = 0; i < IN_DEPTH; i++)
               if (IC'(i) < in_cnt_ff && in_rk_ff[i] > r_i) in_rk_in[i] = in_rk_ff[i] - 1'b1;
            ilast = in_cnt_ff - IC'(1);
            in_pg_in[in_t] = in_pg_ff[ilast[IW-1:0]];
            in_rk_in[in_t] = in_rk_in[ilast[IW-1:0]];
            in_cnt_in = ilast;
            if (gh_cnt_ff >= lim_gh && gh_cnt_ff != '0) begin
               dv_in = 1'b1;
               dp_in = 32'(gh_pg_ff[gh_t]);
               r_g = gh_rk_ff[gh_t];
               for (int i = 0; i < GHOST_DEPTH; i++)
                  if (GC'(i) < gh_cnt_ff && gh_rk_ff[i] > r_g)
                     gh_rk_in[i] = gh_rk_ff[i] - 1'b1;
               glast = gh_cnt_ff - GC'(1);
               gh_pg_in[gh_t] = gh_pg_ff[glast[GW-1:0]];
               gh_rk_in[gh_t] = gh_rk_in[glast[GW-1:0]];
               gh_cnt_in = glast;
            end
            if (32'(gh_cnt_in) < GHOST_DEPTH) begin
               for (int i = 0; i < GHOST_DEPTH; i++)
                  if (GC'(i) < gh_cnt_in) gh_rk_in[i] = gh_rk_in[i] + 1'b1;
               gh_pg_in[gh_cnt_in[GW-1:0]] = q;
               gh_rk_in[gh_cnt_in[GW-1:0]] = '0;
               gh_cnt_in = gh_cnt_in + GC'(1);
            end
         end
         if (32'(in_cnt_in) < IN_DEPTH) begin
            for (int i = 0; i < IN_DEPTH; i++)
               if (IC'(i) < in_cnt_in) in_rk_in[i] = in_rk_in[i] + 1'b1;
            in_pg_in[in_cnt_in[IW-1:0]] = page_ff;
            in_rk_in[in_cnt_in[IW-1:0]] = '0;
            in_cnt_in = in_cnt_in + IC'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) page_ff <= PAGE_BITS'(req_page);
      if (cmd.update) begin
         in_pg_ff <= in_pg_in; gh_pg_ff <= gh_pg_in; mn_pg_ff <= mn_pg_in;
         hit_ff <= hit_in; where_ff <= where_in; dv_ff <= dv_in; dp_ff <= dp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff <= '0; gh_cnt_ff <= '0; mn_cnt_ff <= '0; hits_ff <= '0;
         for (int i = 0; i < IN_DEPTH; i++) in_rk_ff[i] <= '0;
         for (int i = 0; i < GHOST_DEPTH; i++) gh_rk_ff[i] <= '0;
         for (int i = 0; i < MAIN_DEPTH; i++) mn_rk_ff[i] <= '0;
      end else if (cmd.update) begin
         in_cnt_ff <= in_cnt_in; gh_cnt_ff <= gh_cnt_in; mn_cnt_ff <= mn_cnt_in;
         in_rk_ff <= in_rk_in; gh_rk_ff <= gh_rk_in; mn_rk_ff <= mn_rk_in;
         hits_ff <= hits_ff + 32'(hit_in);
      end
   end

   assign rsp_hit           = hit_ff;
   assign rsp_found_in      = where_ff;
   assign rsp_dropped_valid = dv_ff;
   assign rsp_dropped_page  = dp_ff;
   assign rsp_hits_so_far   = hits_ff;

`ifndef ASSERT_OFF
   a_in_cnt: assert property (@(posedge clock) disable iff (reset)
      32'(in_cnt_ff) <= IN_DEPTH) else $error("input list overfull");
   a_gh_cnt: assert property (@(posedge clock) disable iff (reset)
      32'(gh_cnt_ff) <= GHOST_DEPTH) else $error("ghost list overfull");
   a_hit_cnt: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.update) |-> hits_ff == $past(hits_ff) + 32'(hit_ff))
      else $error("hit count slip");
`endif

endmodule

// File: sv/two_queue_page_replacement.sv
// ----------------------------------------------------------------------------
// two_queue_page_replacement: 2Q page replacement tracker
// Tracks page numbers over an input list, a ghost list and a main list.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one page number per word; rsp_ channel returns one
//   word per request: hit, where the page was found, any page dropped from
//   tracking and the running hit count.
//   A request takes three steps: accept, a list update in which all
//   slots are compared and re-ranked in parallel, then the result register.
//   The next request is accepted the cycle after the result is taken, so
//   the block holds only one request at a time.
//   While rsp_stall is high the result holds and req_stall stays high.
//   Reset empties all lists, clears the hit count and loads the limits with
//   16, 32 and 16. csr_ port writes the limits at byte addresses 0, 4, 8;
//   write them only while the block is idle.
// ----------------------------------------------------------------------------
module two_queue_page_replacement
   import tqpr_pkg::*;
#(
   parameter int IN_DEPTH    = 16,
   parameter int GHOST_DEPTH = 32,
   parameter int MAIN_DEPTH  = 16,
   parameter int PAGE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [1:0]  rsp_found_in,
   output logic        rsp_dropped_valid,
   output logic [31:0] rsp_dropped_page,
   output logic [31:0] rsp_hits_so_far,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [4:0] in_lim_ff;
   logic [5:0] gh_lim_ff;
   logic [4:0] mn_lim_ff;
   logic       wr;
   cmd_type    cmd;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_lim_ff <= 5'd16;
         gh_lim_ff <= 6'd32;
         mn_lim_ff <= 5'd16;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            REG_INPUT_LIMIT: in_lim_ff <= csr_pwdata[4:0];
            REG_GHOST_LIMIT: gh_lim_ff <= csr_pwdata[5:0];
            REG_MAIN_LIMIT:  mn_lim_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INPUT_LIMIT: csr_prdata = {27'd0, in_lim_ff};
         REG_GHOST_LIMIT: csr_prdata = {26'd0, gh_lim_ff};
         REG_MAIN_LIMIT:  csr_prdata = {27'd0, mn_lim_ff};
         default:         csr_prdata = '0;
      endcase
   end

   tqpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tqpr_datapath #(
      .IN_DEPTH    (IN_DEPTH),
      .GHOST_DEPTH (GHOST_DEPTH),
      .MAIN_DEPTH  (MAIN_DEPTH),
      .PAGE_BITS   (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_page          (req_page),
      .input_limit       (in_lim_ff),
      .ghost_limit       (gh_lim_ff),
      .main_limit        (mn_lim_ff),
      .rsp_hit           (rsp_hit),
      .rsp_found_in      (rsp_found_in),
      .rsp_dropped_valid (rsp_dropped_valid),
      .rsp_dropped_page  (rsp_dropped_page),
      .rsp_hits_so_far   (rsp_hits_so_far)
   );

endmodule
